[rtl/gdrc_pkg.sv]
// Shared constants and types for the grid ray caster.
// No dependencies; every other file imports this package.
package gdrc_pkg;
  localparam int MapDim     = 64;
  localparam int MapBits    = 6;
  localparam int ScreenRows = 512;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [0:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [0:0] REG_MAP_HEIGHT = 1'b1;

  // Input payload: 169 bits of fields, padded to 176.
  typedef struct packed {
    logic signed [10:0] view_pitch;
    logic [31:0]        delta_y;
    logic [31:0]        delta_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_x;
    logic [21:0]        pos_y;
    logic [21:0]        pos_x;
    logic               cell_is_wall;
    logic [5:0]         cell_y;
    logic [5:0]         cell_x;
    logic               operation;
  } item_t;

  typedef struct packed {
    logic signed [11:0] span_bottom;
    logic [10:0]        span_top;
    logic [15:0]        wall_height;
    logic [31:0]        perp_dist;
    logic               hit_edge;
    logic [6:0]         hit_y;
    logic [6:0]         hit_x;
    logic               hit_side;
  } result_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

[rtl/gdrc_divider.sv]
// Restoring divider, one quotient bit per cycle: (ScreenRows << 16) / divisor.
// Depends on gdrc_pkg.
module gdrc_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         divisor,
  output gdrc_pkg::div_ctl_t  ctl,
  output logic [15:0]         quotient
);
  import gdrc_pkg::*;
  localparam int NumBits = 26;
  localparam logic [NumBits-1:0] Dividend = NumBits'(ScreenRows) << 16;

  logic [NumBits-1:0] num;
  logic [NumBits-1:0] q;
  logic [32:0]        rem;
  logic [4:0]         count;
  logic               busy;
  logic               done;
  logic [32:0]        trial;

  assign trial = {rem[31:0], num[NumBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'(NumBits - 1);
        num <= Dividend;
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          q <= {q[NumBits-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NumBits-2:0], 1'b0};
        end
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 5'd1;
        end
      end
    end
  end

  assign quotient = (q[NumBits-1:16] != '0) ? 16'hFFFF : q[15:0];
  assign ctl = '{start: start, busy: busy, done: done};
endmodule

[rtl/grid_dda_ray_caster_top.sv]
// Top level of the grid ray caster: map memory, DDA sequencer and output register.
// Depends on gdrc_pkg and gdrc_divider.
//
// Use: items arrive on the s_axis channel. Operation 0 writes one map cell and
// produces no transaction on m_axis; operation 1 casts one ray and produces one.
// The map register writes (cfg_we, cfg_index, cfg_data) are taken at any edge
// with cfg_we high and should only happen while the block is idle.
// A cast takes: setup (two shared 32x17 multiplies), then for each DDA step one map
// read, then the compare and edge test, then the serial divider and the draw span.
// The next item is taken only once the result has been accepted; a write is done as
// it is accepted and leaves the block ready for the next item. A cast ends before
// the next item is taken, so the walk length is the limit.
// After reset the map is swept clear, one cell a cycle, over all 4096 cells, and
// s_axis_tready stays low meanwhile. The result waits in an output register
// while m_axis_tready is low; the next item is accepted only once that register
// is free, so a stalled receiver holds the block.
module grid_dda_ray_caster_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation, cell_x, cell_y, cell_is_wall, pos_x, pos_y, dir_x, dir_y,
  // delta_x, delta_y, view_pitch; zero padding to 176 bits.
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_side, hit_x, hit_y, hit_edge, perp_dist, wall_height, span_top,
  // span_bottom; zero padding to 88 bits.
  output logic [87:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [6:0]   cfg_data
);
  import gdrc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_TEST  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_SPAN  = 3'd6;

  logic [2:0]  state;
  logic [6:0]  map_width;
  logic [6:0]  map_height;
  logic        wall_map [MapDim*MapDim];
  logic        map_rd;
  logic [2*MapBits-1:0] clr_addr;
  item_t       item;
  item_t       in_item;
  logic signed [8:0] cx;
  logic signed [8:0] cy;
  logic [31:0] sdx;
  logic [31:0] sdy;
  logic        side;
  logic        edge_hit;
  logic        init_axis;
  logic [48:0] prod;
  logic [16:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] perp;
  logic        div_start;
  div_ctl_t    div_ctl;
  logic [15:0] quotient;
  result_t     res;
  logic        out_valid;
  logic [32:0] sum_x;
  logic [32:0] sum_y;
  logic        edge_now;
  logic signed [8:0] nx;
  logic signed [8:0] ny;
  logic signed [17:0] ds;
  logic signed [17:0] de;
  logic [15:0] lh;
  logic        in_array;

  assign in_item = item_t'(s_axis_tdata[168:0]);
  assign s_axis_tready = (state == ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= 7'd64;
      map_height <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier for the two initial side distances.
  always_comb begin
    if (!init_axis) begin
      mul_a = item.dir_x[17] ? {1'b0, item.pos_x[15:0]} : 17'h10000 - {1'b0, item.pos_x[15:0]};
      mul_b = item.delta_x;
    end else begin
      mul_a = item.dir_y[17] ? {1'b0, item.pos_y[15:0]} : 17'h10000 - {1'b0, item.pos_y[15:0]};
      mul_b = item.delta_y;
    end
  end
  assign prod = mul_a * mul_b;

  assign sum_x = {1'b0, sdx} + {1'b0, item.delta_x};
  assign sum_y = {1'b0, sdy} + {1'b0, item.delta_y};
  assign nx = (sdx < sdy) ? (item.dir_x[17] ? cx - 9'sd1 : cx + 9'sd1) : cx;
  assign ny = (sdx < sdy) ? cy : (item.dir_y[17] ? cy - 9'sd1 : cy + 9'sd1);
  assign edge_now = (ny >= $signed({2'b0, map_height}) - 9'sd1)
                 || (nx > $signed({2'b0, map_width})) || (ny <= 9'sd0) || (nx <= 9'sd0);

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      wall_map[clr_addr] <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready && in_item.operation == OP_WRITE) begin
      wall_map[{in_item.cell_x, in_item.cell_y}] <= in_item.cell_is_wall;
    end
    map_rd <= wall_map[{nx[MapBits-1:0], ny[MapBits-1:0]}];
  end

  assign in_array = (cx >= 9'sd0) && (cy >= 9'sd0) && (cx < 9'sd64) && (cy < 9'sd64);

  assign perp = side ? sdy - item.delta_y : sdx - item.delta_x;
  assign div_start = (state == ST_TEST) && (edge_hit || (map_rd && in_array));

  gdrc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(perp),
    .ctl(div_ctl), .quotient(quotient)
  );

  assign lh = (perp == '0) ? 16'hFFFF : quotient;
  always_comb begin
    ds = 18'sd256 - $signed({3'b0, lh[15:1]}) + 18'($signed(item.view_pitch));
    de = 18'sd256 + $signed({3'b0, lh[15:1]}) + 18'($signed(item.view_pitch));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      init_axis <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready && in_item.operation == OP_CAST) begin
            item <= in_item;
            cx <= {3'b0, in_item.pos_x[21:16]};
            cy <= {3'b0, in_item.pos_y[21:16]};
            init_axis <= 1'b0;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          if (!init_axis) begin
            sdx <= prod[47:16];
            init_axis <= 1'b1;
          end else begin
            sdy <= prod[47:16];
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (sdx < sdy) begin
            sdx <= sum_x[32] ? 32'hFFFFFFFF : sum_x[31:0];
            side <= 1'b0;
          end else begin
            sdy <= sum_y[32] ? 32'hFFFFFFFF : sum_y[31:0];
            side <= 1'b1;
          end
          cx <= nx;
          cy <= ny;
          edge_hit <= edge_now;
          state <= ST_TEST;
        end
        ST_TEST: begin
          if (edge_hit || (map_rd && in_array)) state <= ST_DIV;
          else state <= ST_STEP;
        end
        ST_DIV: begin
          if (div_ctl.done) state <= ST_SPAN;
        end
        ST_SPAN: begin
          res.hit_side <= side;
          res.hit_x <= cx[6:0];
          res.hit_y <= cy[6:0];
          res.hit_edge <= edge_hit;
          res.perp_dist <= perp;
          res.wall_height <= lh;
          res.span_top <= ds[17] ? 11'd0 : ds[10:0];
          res.span_bottom <= (de >= 18'sd512) ? 12'sd511 : de[11:0];
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {1'b0, res};

  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !out_valid)
    else $error("input accepted while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
    div_ctl.busy |-> state == ST_DIV)
    else $error("divider running outside the divide phase");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPAN) |=> out_valid)
    else $error("result not presented after span");
endmodule

[dv/grid_dda_ray_caster_checker.sv]
// Checker for the grid ray caster: watches the item, result and register ports,
// predicts every cast result and compares it field by field.
// Depends on gdrc_pkg for the item and result layouts.
`timescale 1ns / 100ps

module grid_dda_ray_caster_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [87:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [6:0]   cfg_data,
  output int           fail_count,
  output int           pending
);
  import gdrc_pkg::*;

  bit        wall_bits [MapDim*MapDim];
  int        cols_bound;
  int        rows_bound;
  result_t   hits_due [$];

  function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic result_t cast_ray(item_t it);
    result_t r;
    int cx, cy, sx, sy, side, half, ds, de;
    bit edge_hit, neg_x, neg_y, blocked;
    longint unsigned fr_x, fr_y;
    logic [31:0] sdx, sdy, perp, lh;
    logic [47:0] quo;
    neg_x = it.dir_x[17];
    neg_y = it.dir_y[17];
    cx = int'(it.pos_x[21:16]);
    cy = int'(it.pos_y[21:16]);
    sx = neg_x ? -1 : 1;
    sy = neg_y ? -1 : 1;
    fr_x = neg_x ? it.pos_x[15:0] : 65536 - it.pos_x[15:0];
    fr_y = neg_y ? it.pos_y[15:0] : 65536 - it.pos_y[15:0];
    sdx = 32'((fr_x * it.delta_x) >> 16);
    sdy = 32'((fr_y * it.delta_y) >> 16);
    side = 0;
    forever begin
      if (sdx < sdy) begin
        sdx = add_clamped(sdx, it.delta_x);
        cx += sx;
        side = 0;
      end else begin
        sdy = add_clamped(sdy, it.delta_y);
        cy += sy;
        side = 1;
      end
      edge_hit = cy >= rows_bound - 1 || cx > cols_bound || cy <= 0 || cx <= 0;
      blocked = cx >= 0 && cy >= 0 && cx < MapDim && cy < MapDim
        && wall_bits[cx*MapDim + cy];
      if (edge_hit || blocked) break;
    end
    perp = side == 0 ? sdx - it.delta_x : sdy - it.delta_y;
    if (perp == 0) begin
      lh = 32'hFFFF;
    end else begin
      quo = (48'(ScreenRows) << 16) / perp;
      lh = quo > 48'hFFFF ? 32'hFFFF : quo[31:0];
    end
    half = int'(lh / 2);
    ds = ScreenRows / 2 - half + int'($signed(it.view_pitch));
    if (ds < 0) ds = 0;
    de = half + ScreenRows / 2 + int'($signed(it.view_pitch));
    if (de >= ScreenRows) de = ScreenRows - 1;
    r.hit_side    = side[0];
    r.hit_x       = cx[6:0];
    r.hit_y       = cy[6:0];
    r.hit_edge    = edge_hit;
    r.perp_dist   = perp;
    r.wall_height = lh[15:0];
    r.span_top    = ds[10:0];
    r.span_bottom = de[11:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    cols_bound = 64;
    rows_bound = 64;
    foreach (wall_bits[i]) wall_bits[i] = 0;
  end

  always @(posedge clk) begin
    item_t   it;
    result_t got, want;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == REG_MAP_WIDTH) cols_bound = int'(cfg_data);
        else rows_bound = int'(cfg_data);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it = item_t'(s_axis_tdata[168:0]);
        if (it.operation == OP_WRITE) wall_bits[it.cell_x*MapDim + it.cell_y] = it.cell_is_wall;
        else hits_due.push_back(cast_ray(it));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[86:0]);
        if (hits_due.size() == 0) begin
          $error("result transaction with no cast outstanding");
          fail_count++;
        end else begin
          want = hits_due.pop_front();
          if (got.hit_side !== want.hit_side) begin
            $error("hit_side expected %0d got %0d", want.hit_side, got.hit_side);
            fail_count++;
          end
          if (got.hit_x !== want.hit_x) begin
            $error("hit_x expected %0d got %0d", want.hit_x, got.hit_x);
            fail_count++;
          end
          if (got.hit_y !== want.hit_y) begin
            $error("hit_y expected %0d got %0d", want.hit_y, got.hit_y);
            fail_count++;
          end
          if (got.hit_edge !== want.hit_edge) begin
            $error("hit_edge expected %0d got %0d", want.hit_edge, got.hit_edge);
            fail_count++;
          end
          if (got.perp_dist !== want.perp_dist) begin
            $error("perp_dist expected %h got %h", want.perp_dist, got.perp_dist);
            fail_count++;
          end
          if (got.wall_height !== want.wall_height) begin
            $error("wall_height expected %0d got %0d", want.wall_height, got.wall_height);
            fail_count++;
          end
          if (got.span_top !== want.span_top) begin
            $error("span_top expected %0d got %0d", want.span_top, got.span_top);
            fail_count++;
          end
          if (got.span_bottom !== want.span_bottom) begin
            $error("span_bottom expected %0d got %0d", want.span_bottom, got.span_bottom);
            fail_count++;
          end
        end
      end
    end
    pending = hits_due.size();
  end

endmodule

[dv/grid_dda_ray_caster_top_tb.sv]
// Testbench top for the grid ray caster: clock, reset, item and register stimulus,
// result back-pressure and the verdict. Depends on gdrc_pkg, the block and the checker.
`timescale 1ns / 100ps

module grid_dda_ray_caster_top_tb;
  import gdrc_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [87:0]  m_axis_tdata;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [6:0]   cfg_data;
  int           fail_count;
  int           pending;
  bit           no_gaps;
  bit           long_hold;

  grid_dda_ray_caster_top u_top (.*);

  grid_dda_ray_caster_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic item_t cell_write(int x, int y, bit wall);
    item_t it;
    it = '0;
    it.operation = OP_WRITE;
    it.cell_x = 6'(x);
    it.cell_y = 6'(y);
    it.cell_is_wall = wall;
    return it;
  endfunction

  function automatic item_t ray(logic [21:0] px, logic [21:0] py, logic [17:0] dx,
                                logic [17:0] dy, logic [31:0] lx, logic [31:0] ly,
                                logic [10:0] pitch);
    item_t it;
    it = '0;
    it.operation = OP_CAST;
    it.pos_x = px;
    it.pos_y = py;
    it.dir_x = dx;
    it.dir_y = dy;
    it.delta_x = lx;
    it.delta_y = ly;
    it.view_pitch = pitch;
    return it;
  endfunction

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom();
      default: return $urandom_range(32'h4000, 32'h80000);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    if ($urandom_range(0, 9) < 4) begin
      it = cell_write($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 2) == 0);
      it.pos_x = 22'($urandom());
      it.delta_y = $urandom();
    end else begin
      it = ray(22'($urandom()), 22'($urandom()), 18'($urandom()), 18'($urandom()),
               pick_delta(), pick_delta(), 11'($urandom()));
      it.cell_x = 6'($urandom());
      it.cell_is_wall = 1'($urandom());
    end
    return it;
  endfunction

  task automatic send(item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, it};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic settle_and_configure(int cols, int rows);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= 7'(cols);
    @(posedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data <= 7'(rows);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (long_hold) begin
        long_hold = 1'b0;
        stall = 1500;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    int cols [6] = '{64, 1, 64, 1, 17, 40};
    int rows [6] = '{64, 1, 1, 64, 40, 9};
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MAP_WIDTH;
    cfg_data = '0;
    no_gaps = 1'b0;
    long_hold = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    settle_and_configure(64, 64);

    send(cell_write(0, 0, 1'b1));
    send(cell_write(63, 63, 1'b1));
    send(cell_write(12, 10, 1'b1));
    send(cell_write(10, 14, 1'b1));
    send(ray(22'h0A8000, 22'h0A8000, 18'h10000, 18'h0, 32'h10000, 32'h20000, 11'd0));
    send(ray(22'h0A8000, 22'h0A8000, 18'h3FFFF, 18'h20000, 32'h18000, 32'h18000, 11'h400));
    send(ray(22'h0A8000, 22'h0A8000, 18'h0, 18'h1FFFF, 32'h30000, 32'h8000, 11'h3FF));
    send(ray(22'h0, 22'h0, 18'h20000, 18'h20000, 32'h10000, 32'h10000, 11'd0));
    send(ray(22'h3FFFFF, 22'h3FFFFF, 18'h1FFFF, 18'h1FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 11'h7FF));
    send(ray(22'h050000, 22'h050000, 18'h0, 18'h0, 32'h0, 32'h0, 11'd5));
    send(ray(22'h020000, 22'h200000, 18'h0, 18'h0, 32'hFFFF_FFFF, 32'h0, 11'h400));
    send(ray(22'h3F0000, 22'h208000, 18'h0, 18'h20000, 32'h10000, 32'h90000, 11'd0));
    send(ray(22'h018000, 22'h018000, 18'h20000, 18'h20000, 32'h1, 32'h2, 11'd0));
    send(cell_write(12, 10, 1'b0));
    send(ray(22'h0A8000, 22'h0A8000, 18'h10000, 18'h0, 32'h10000, 32'h20000, 11'd0));
    send(ray(22'h0A0001, 22'h0AFFFF, 18'h10000, 18'h3FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 11'h200));

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) settle_and_configure(cols[ph], rows[ph]);
      for (int n = 0; n < 110; n++) begin
        no_gaps = (n >= 40 && n < 60);
        if (ph == 0 && n == 70) long_hold = 1'b1;
        send(random_item());
      end
      no_gaps = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
